FILE: src/mg4b_pkg.sv
// Shared types and constants of the mono glyph to 4bpp blitter.
// No dependencies; every other file of the block imports this package.
package mg4b_pkg;

	localparam int MAX_PITCH       = 1024;
	localparam int MAX_GLYPH_WIDTH = 256;
	localparam int MAX_ROW_BYTES   = 32;
	localparam int NUM_SLOTS       = 5;
	localparam int OFF_W           = 19;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 11;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INK          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_PITCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_X       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 3'd7;

	typedef struct packed {
		logic [3:0]  ink;
		logic [10:0] canvas_pitch;
		logic [9:0]  area_left;
		logic [9:0]  area_top;
		logic [8:0]  area_width;
		logic [8:0]  area_height;
		logic [7:0]  skip_x;
		logic [5:0]  row_bytes;
	} mg4b_cfg_t;

	typedef struct packed {
		logic [7:0] glyph_byte;
		logic       first;
	} mg4b_in_t;

	typedef struct packed {
		logic [OFF_W-1:0] byte_offset;
		logic [7:0]       pixel_byte;
		logic [1:0]       nibble_enable;
		logic             last;
	} mg4b_out_t;

	// one classified glyph byte handed from the front to the back end
	typedef struct packed {
		logic [7:0]       gbyte;
		logic [4:0]       byte_in_row;
		logic [OFF_W-1:0] row_base;
	} mg4b_rec_t;

endpackage

FILE: src/mg4b_front.sv
// Front end: accepts glyph bytes, tracks row, byte and row base offset, drops finished draws.
// Depends on mg4b_pkg.
module mg4b_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mg4b_pkg::mg4b_cfg_t   cfg,
	input  logic                  glyph_valid,
	output logic                  glyph_stall,
	input  mg4b_pkg::mg4b_in_t    glyph,
	input  logic                  push_ready,
	output logic                  push,
	output mg4b_pkg::mg4b_rec_t   push_rec
);
	import mg4b_pkg::*;

	logic [8:0]       row_count_q;
	logic [4:0]       byte_in_row_q;
	logic [OFF_W-1:0] row_base_q;
	logic [8:0]       row_cur;
	logic [4:0]       byte_cur;
	logic [OFF_W-1:0] base_cur;
	logic [10:0]      pitch_c;
	logic [9:0]       stride;
	logic [19:0]      top_prod;
	logic [5:0]       row_len;
	logic [5:0]       byte_nxt;
	logic             row_wrap;
	logic             active;
	logic             accept;

	assign glyph_stall = ~push_ready;
	assign accept      = glyph_valid & ~glyph_stall;

	always_comb begin
		if (cfg.row_bytes == 6'd0) begin
			row_len = 6'd1;
		end else if (cfg.row_bytes > 6'(MAX_ROW_BYTES)) begin
			row_len = 6'(MAX_ROW_BYTES);
		end else begin
			row_len = cfg.row_bytes;
		end
	end

	always_comb begin
		pitch_c = (cfg.canvas_pitch > 11'(MAX_PITCH)) ? 11'(MAX_PITCH) : cfg.canvas_pitch;
		stride  = 10'((12'(pitch_c) + 12'd1) >> 1);
	end

	// row base is latched at the start of a draw and then stepped by the stride
	assign top_prod = cfg.area_top * stride;

	assign row_cur  = glyph.first ? 9'd0 : row_count_q;
	assign byte_cur = glyph.first ? 5'd0 : byte_in_row_q;
	assign base_cur = glyph.first ? top_prod[OFF_W-1:0] : row_base_q;
	assign active   = row_cur < cfg.area_height;
	assign byte_nxt = {1'b0, byte_cur} + 6'd1;
	assign row_wrap = byte_nxt >= row_len;

	assign push                 = accept & active;
	assign push_rec.gbyte       = glyph.glyph_byte;
	assign push_rec.byte_in_row = byte_cur;
	assign push_rec.row_base    = base_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= '0;
			byte_in_row_q <= '0;
			row_base_q    <= '0;
		end else if (accept) begin
			if (active) begin
				byte_in_row_q <= row_wrap ? 5'd0 : byte_nxt[4:0];
				row_count_q   <= row_wrap ? row_cur + 9'd1 : row_cur;
				row_base_q    <= row_wrap ? base_cur + OFF_W'(stride) : base_cur;
			end else begin
				byte_in_row_q <= byte_cur;
				row_count_q   <= row_cur;
				row_base_q    <= base_cur;
			end
		end
	end

endmodule

FILE: src/mg4b_fifo.sv
// Small first-word-fall-through queue of classified glyph bytes.
// Depends on mg4b_pkg.
module mg4b_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mg4b_pkg::mg4b_rec_t push_rec,
	output logic                push_ready,
	input  logic                pop,
	output logic                pop_valid,
	output mg4b_pkg::mg4b_rec_t pop_rec
);
	import mg4b_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mg4b_rec_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_rec    = mem_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: src/mg4b_back.sv
// Back end: clips and maps a glyph byte to up to five nibble-masked canvas writes,
// then emits them one per cycle while wr_stall is low, through a registered output. Depends on mg4b_pkg.
module mg4b_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mg4b_pkg::mg4b_cfg_t cfg,
	input  logic                q_valid,
	input  mg4b_pkg::mg4b_rec_t q_rec,
	output logic                q_pop,
	output logic                wr_valid,
	input  logic                wr_stall,
	output mg4b_pkg::mg4b_out_t wr
);
	import mg4b_pkg::*;

	localparam int EW = 2 * NUM_SLOTS;

	// stage 1 inputs
	logic [8:0]       width_c;
	logic [9:0]       win_end;
	logic [7:0]       pix_base;
	logic [7:0]       pix;
	logic [7:0]       mask;
	logic [11:0]      col_base;
	logic [EW-1:0]    en_c;

	// stage 1 registers
	logic             valid_s1;
	logic [EW-1:0]    en_s1;
	logic [10:0]      bstart_s1;
	logic [OFF_W-1:0] rowbase_s1;

	// emitter
	logic [EW-1:0]    rem_q;
	logic [OFF_W-1:0] base_q;
	logic             wr_valid_q;
	mg4b_out_t        wr_q;
	logic [2:0]       sel;
	logic [1:0]       sel_en;
	logic [EW-1:0]    rem_after;
	logic             have;
	logic             out_free;
	logic             emit;
	logic             load;
	logic             s1_take;

	always_comb begin
		width_c = (cfg.area_width > 9'(MAX_GLYPH_WIDTH)) ? 9'(MAX_GLYPH_WIDTH)
			: cfg.area_width;
		win_end = {2'b00, cfg.skip_x} + {1'b0, width_c};
	end

	// clip mask, k = 0 is the leftmost pixel (msb of the glyph byte)
	always_comb begin
		pix_base = {q_rec.byte_in_row, 3'b000};
		pix      = '0;
		mask     = '0;
		for (int k = 0; k < 8; k++) begin
			pix     = pix_base + 8'(k);
			mask[k] = q_rec.gbyte[7-k] && (pix >= cfg.skip_x) && ({2'b00, pix} < win_end);
		end
	end

	// destination column of pixel 0, may be negative when it lies left of the window
	assign col_base = {2'b00, cfg.area_left} + {4'b0000, pix_base} - {4'b0000, cfg.skip_x};

	// slot j is destination byte (col_base >> 1) + j; bit1 upper nibble, bit0 lower
	always_comb begin
		en_c = '0;
		if (!col_base[0]) begin
			for (int j = 0; j < 4; j++) begin
				en_c[2*j+1] = mask[2*j];
				en_c[2*j]   = mask[2*j+1];
			end
		end else begin
			en_c[0] = mask[0];
			for (int j = 1; j < 4; j++) begin
				en_c[2*j+1] = mask[2*j-1];
				en_c[2*j]   = mask[2*j];
			end
			en_c[9] = mask[7];
		end
	end

	// emitter slot pick: lowest slot still holding enabled nibbles
	always_comb begin
		sel    = '0;
		sel_en = '0;
		for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
			if (rem_q[2*j +: 2] != 2'b00) begin
				sel    = 3'(j);
				sel_en = rem_q[2*j +: 2];
			end
		end
		rem_after = rem_q & ~(EW'(2'b11) << (2 * sel));
	end

	assign have     = rem_q != '0;
	assign out_free = ~wr_valid_q | ~wr_stall;
	assign emit     = have & out_free;
	assign load     = valid_s1 & (~have | (emit & (rem_after == '0)));
	assign s1_take  = ~valid_s1 | load;
	assign q_pop    = q_valid & s1_take;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			en_s1      <= en_c;
			bstart_s1  <= col_base[11:1];
			rowbase_s1 <= q_rec.row_base;
		end
		if (load) begin
			base_q <= rowbase_s1 + {{(OFF_W - 11){bstart_s1[10]}}, bstart_s1};
		end
		if (emit) begin
			wr_q.byte_offset   <= base_q + OFF_W'(sel);
			wr_q.pixel_byte    <= {cfg.ink, cfg.ink};
			wr_q.nibble_enable <= sel_en;
			wr_q.last          <= rem_after == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			rem_q      <= '0;
			wr_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				valid_s1 <= q_valid;
			end
			if (load) begin
				rem_q <= en_s1;
			end else if (emit) begin
				rem_q <= rem_after;
			end
			if (emit) begin
				wr_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				wr_valid_q <= 1'b0;
			end
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

endmodule

FILE: src/mono_glyph_to_4bpp_blit.sv
// Top level of the 1bpp glyph to packed 4bpp canvas blitter: config registers,
// front end, queue and back end. Depends on mg4b_pkg, mg4b_front, mg4b_fifo, mg4b_back.
//
//   channel  dir  handshake                payload
//   glyph    in   glyph_valid / glyph_stall  mg4b_in_t  (glyph_byte, first)
//   wr       out  wr_valid / wr_stall        mg4b_out_t (byte_offset, pixel_byte,
//                                                        nibble_enable, last)
//   cfg      in   cfg_we                     cfg_index, cfg_data
//
// Each glyph byte yields zero to five canvas writes; the back end emits one write per
// cycle while wr_stall is low, and the next byte's mapping overlaps the current byte's
// last write. An accepted byte passes the queue, the stage 1 registers and the emitter
// before its first write is registered on the output. The front end takes a byte each
// cycle while the queue has room. Reset clears the row, byte and row base counters and
// sets all config registers to their defaults; no clearing pass is needed.
module mono_glyph_to_4bpp_blit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     glyph_valid,
	output logic                                     glyph_stall,
	input  mg4b_pkg::mg4b_in_t                       glyph,
	output logic                                     wr_valid,
	input  logic                                     wr_stall,
	output mg4b_pkg::mg4b_out_t                      wr,
	input  logic                                     cfg_we,
	input  logic [mg4b_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [mg4b_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import mg4b_pkg::*;

	mg4b_cfg_t cfg_q;
	logic      push;
	logic      push_ready;
	mg4b_rec_t push_rec;
	logic      q_valid;
	logic      q_pop;
	mg4b_rec_t q_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ink          <= 4'd0;
			cfg_q.canvas_pitch <= 11'(MAX_PITCH);
			cfg_q.area_left    <= 10'd0;
			cfg_q.area_top     <= 10'd0;
			cfg_q.area_width   <= 9'd1;
			cfg_q.area_height  <= 9'd1;
			cfg_q.skip_x       <= 8'd0;
			cfg_q.row_bytes    <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INK:          cfg_q.ink          <= cfg_data[3:0];
				CFG_CANVAS_PITCH: cfg_q.canvas_pitch <= cfg_data[10:0];
				CFG_AREA_LEFT:    cfg_q.area_left    <= cfg_data[9:0];
				CFG_AREA_TOP:     cfg_q.area_top     <= cfg_data[9:0];
				CFG_AREA_WIDTH:   cfg_q.area_width   <= cfg_data[8:0];
				CFG_AREA_HEIGHT:  cfg_q.area_height  <= cfg_data[8:0];
				CFG_SKIP_X:       cfg_q.skip_x       <= cfg_data[7:0];
				CFG_ROW_BYTES:    cfg_q.row_bytes    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	mg4b_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph       (glyph),
		.push_ready  (push_ready),
		.push        (push),
		.push_rec    (push_rec)
	);

	mg4b_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_rec    (q_rec)
	);

	mg4b_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_rec    (q_rec),
		.q_pop    (q_pop),
		.wr_valid (wr_valid),
		.wr_stall (wr_stall),
		.wr       (wr)
	);

endmodule

FILE: src/mg4b_chk.sv
// Port-level checks on the blitter's write channel, bound to the top level.
// Depends on mg4b_pkg and mono_glyph_to_4bpp_blit.
module mg4b_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                wr_valid,
	input logic                wr_stall,
	input mg4b_pkg::mg4b_out_t wr
);
	import mg4b_pkg::*;

	logic             open_q;
	logic [OFF_W-1:0] prev_off_q;

	// open_q: an accepted write without last, so more writes of the same item follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (wr_valid && !wr_stall) begin
			open_q <= ~wr.last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && !wr_stall) begin
			prev_off_q <= wr.byte_offset;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && wr_stall |=> wr_valid && $stable(wr))
		else $error("write changed while stalled");

	a_nib_en: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> wr.nibble_enable != 2'b00)
		else $error("write with no nibble enabled");

	a_colour: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> wr.pixel_byte[7:4] == wr.pixel_byte[3:0])
		else $error("pixel byte nibbles differ");

	a_merge: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && open_q |-> wr.byte_offset != prev_off_q)
		else $error("same destination byte written twice for one item");

endmodule

bind mono_glyph_to_4bpp_blit mg4b_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.wr_valid (wr_valid),
	.wr_stall (wr_stall),
	.wr       (wr)
);
